// File: rtl/core/valid_pixel_bounding_box_unit_defines.svh
// Assertion macros for the valid pixel bounding box unit.
`ifndef VALID_PIXEL_BOUNDING_BOX_UNIT_DEFINES_SVH
`define VALID_PIXEL_BOUNDING_BOX_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

// Check that a condition holds on every clock outside reset.
`define VPBB_ASSERT_ALWAYS(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
		else $error("assertion failed: cond");

// Check that a consequent holds whenever the antecedent holds.
`define VPBB_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed: ante implies cons");

`else

`define VPBB_ASSERT_ALWAYS(label, clk, rst_n, cond)
`define VPBB_ASSERT_IMPL(label, clk, rst_n, ante, cons)

`endif

`endif

// File: rtl/core/vpbb_pkg.sv
// Shared constants and types for the valid pixel bounding box unit.
package vpbb_pkg;

	localparam int IDX_W       = 12;
	localparam int COORD_W     = 48;
	localparam int RES_W       = 32;
	localparam int CFG_ROWS_W  = 13;
	localparam int CFG_COLS_W  = 13;
	localparam int CFG_DATA_W  = 48;
	localparam int CFG_IDX_W   = 3;

	localparam int DEF_MAX_ROWS = 4096;
	localparam int DEF_MAX_COLS = 4096;

	localparam logic [RES_W-1:0] RES_RESET = 32'd65536;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FRAME_ROWS    = 3'd0,
		REG_FRAME_COLS    = 3'd1,
		REG_NORTH_EDGE    = 3'd2,
		REG_WEST_EDGE     = 3'd3,
		REG_NS_RESOLUTION = 3'd4,
		REG_EW_RESOLUTION = 3'd5
	} cfg_idx_t;

endpackage

// File: rtl/core/vpbb_tracker.sv
// Cell counters and running bounding box; emits one box per frame.
module vpbb_tracker import vpbb_pkg::*; #(
	parameter int MAX_ROWS = DEF_MAX_ROWS,
	parameter int MAX_COLS = DEF_MAX_COLS,
	localparam int RW = $clog2(MAX_ROWS),
	localparam int CW = $clog2(MAX_COLS)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [CFG_ROWS_W-1:0] frame_rows,
	input  logic [CFG_COLS_W-1:0] frame_cols,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic                  has_data,
	output logic                  box_valid,
	input  logic                  box_ready,
	output logic                  box_found,
	output logic [RW-1:0]         box_min_row,
	output logic [RW-1:0]         box_max_row,
	output logic [CW-1:0]         box_min_col,
	output logic [CW-1:0]         box_max_col
);

	localparam int RXW = (RW + 1 > CFG_ROWS_W) ? RW + 1 : CFG_ROWS_W;
	localparam int CXW = (CW + 1 > CFG_COLS_W) ? CW + 1 : CFG_COLS_W;

	logic [RXW-1:0] rows_x;
	logic [CXW-1:0] cols_x;
	logic [RW-1:0]  last_row;
	logic [CW-1:0]  last_col;

	logic [RW-1:0] row_q, min_row_q, max_row_q;
	logic [CW-1:0] col_q, min_col_q, max_col_q;
	logic          any_q;

	logic [RW-1:0] nxt_min_row, nxt_max_row;
	logic [CW-1:0] nxt_min_col, nxt_max_col;
	logic          nxt_any;

	logic row_end, col_end, frame_end, accept, valid_s1;

	// Clamp the frame size to 1..MAX and take the last position
	always_comb begin
		rows_x = RXW'(frame_rows);
		if (rows_x == '0) begin
			last_row = '0;
		end else if (rows_x > RXW'(MAX_ROWS)) begin
			last_row = RW'(MAX_ROWS - 1);
		end else begin
			last_row = RW'(rows_x - 1'b1);
		end
		cols_x = CXW'(frame_cols);
		if (cols_x == '0) begin
			last_col = '0;
		end else if (cols_x > CXW'(MAX_COLS)) begin
			last_col = CW'(MAX_COLS - 1);
		end else begin
			last_col = CW'(cols_x - 1'b1);
		end
	end

	assign col_end   = (col_q >= last_col);
	assign row_end   = (row_q >= last_row);
	assign frame_end = row_end && col_end;

	// Only a frame-ending cell needs room in the result stage
	assign in_ready = !frame_end || !valid_s1 || box_ready;
	assign accept   = in_valid && in_ready;

	// Fold the current cell into the box
	always_comb begin
		nxt_any     = any_q | has_data;
		nxt_min_row = min_row_q;
		nxt_max_row = max_row_q;
		nxt_min_col = min_col_q;
		nxt_max_col = max_col_q;
		if (has_data && !any_q) begin
			nxt_min_row = row_q;
			nxt_max_row = row_q;
			nxt_min_col = col_q;
			nxt_max_col = col_q;
		end else if (has_data) begin
			if (row_q < min_row_q) nxt_min_row = row_q;
			if (row_q > max_row_q) nxt_max_row = row_q;
			if (col_q < min_col_q) nxt_min_col = col_q;
			if (col_q > max_col_q) nxt_max_col = col_q;
		end
	end

	// Advance counters and box; clear both at frame end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q     <= '0;
			col_q     <= '0;
			min_row_q <= '1;
			max_row_q <= '0;
			min_col_q <= '1;
			max_col_q <= '0;
			any_q     <= 1'b0;
		end else if (accept) begin
			if (frame_end) begin
				row_q     <= '0;
				col_q     <= '0;
				min_row_q <= '1;
				max_row_q <= '0;
				min_col_q <= '1;
				max_col_q <= '0;
				any_q     <= 1'b0;
			end else begin
				if (col_end) begin
					col_q <= '0;
					row_q <= row_q + 1'b1;
				end else begin
					col_q <= col_q + 1'b1;
				end
				min_row_q <= nxt_min_row;
				max_row_q <= nxt_max_row;
				min_col_q <= nxt_min_col;
				max_col_q <= nxt_max_col;
				any_q     <= nxt_any;
			end
		end
	end

	// Hold the finished frame box until the edge stage takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept && frame_end) begin
			valid_s1 <= 1'b1;
		end else if (box_ready) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && frame_end) begin
			box_found   <= nxt_any;
			box_min_row <= nxt_min_row;
			box_max_row <= nxt_max_row;
			box_min_col <= nxt_min_col;
			box_max_col <= nxt_max_col;
		end
	end

	assign box_valid = valid_s1;

endmodule

// File: rtl/core/vpbb_edge_calc.sv
// Map edge computation: multiply stage, then add, saturate and output register.
module vpbb_edge_calc import vpbb_pkg::*; #(
	parameter int MAX_ROWS = DEF_MAX_ROWS,
	parameter int MAX_COLS = DEF_MAX_COLS,
	localparam int RW = $clog2(MAX_ROWS),
	localparam int CW = $clog2(MAX_COLS)
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic signed [COORD_W-1:0] north_edge,
	input  logic signed [COORD_W-1:0] west_edge,
	input  logic [RES_W-1:0]          ns_resolution,
	input  logic [RES_W-1:0]          ew_resolution,
	input  logic                      box_valid,
	output logic                      box_ready,
	input  logic                      box_found,
	input  logic [RW-1:0]             box_min_row,
	input  logic [RW-1:0]             box_max_row,
	input  logic [CW-1:0]             box_min_col,
	input  logic [CW-1:0]             box_max_col,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic                      found,
	output logic [IDX_W-1:0]          top_row,
	output logic [IDX_W-1:0]          bottom_row,
	output logic [IDX_W-1:0]          left_col,
	output logic [IDX_W-1:0]          right_col,
	output logic signed [COORD_W-1:0] new_north,
	output logic signed [COORD_W-1:0] new_south,
	output logic signed [COORD_W-1:0] new_west,
	output logic signed [COORD_W-1:0] new_east
);

	localparam int PRW = RW + 1 + RES_W;
	localparam int PCW = CW + 1 + RES_W;
	localparam int PW  = (PRW > PCW) ? PRW : PCW;
	localparam int SW  = ((PW > COORD_W) ? PW : COORD_W) + 2;

	localparam logic signed [SW-1:0] QMAX = {{(SW-COORD_W+1){1'b0}}, {(COORD_W-1){1'b1}}};
	localparam logic signed [SW-1:0] QMIN = {{(SW-COORD_W+1){1'b1}}, {(COORD_W-1){1'b0}}};

	logic [RW+IDX_W-1:0] min_row_x, max_row_x;
	logic [CW+IDX_W-1:0] min_col_x, max_col_x;

	logic             valid_s2, found_s2;
	logic [IDX_W-1:0] top_s2, bottom_s2, left_s2, right_s2;
	logic [PRW-1:0]   p_north_s2, p_south_s2;
	logic [PCW-1:0]   p_west_s2, p_east_s2;

	logic                      valid_s3, found_s3;
	logic [IDX_W-1:0]          top_s3, bottom_s3, left_s3, right_s3;
	logic signed [COORD_W-1:0] north_s3, south_s3, west_s3, east_s3;

	logic signed [SW-1:0] n_x, w_x, sum_north, sum_south, sum_west, sum_east;
	logic                 rdy_s3, rdy_s2;

	function automatic logic signed [COORD_W-1:0] sat_coord(input logic signed [SW-1:0] v);
		logic signed [COORD_W-1:0] r;
		if (v > QMAX) begin
			r = QMAX[COORD_W-1:0];
		end else if (v < QMIN) begin
			r = QMIN[COORD_W-1:0];
		end else begin
			r = v[COORD_W-1:0];
		end
		return r;
	endfunction

	assign rdy_s3    = !valid_s3 || out_ready;
	assign rdy_s2    = !valid_s2 || rdy_s3;
	assign box_ready = rdy_s2;

	// Keep the low index bits for the result fields
	assign min_row_x = {{IDX_W{1'b0}}, box_min_row};
	assign max_row_x = {{IDX_W{1'b0}}, box_max_row};
	assign min_col_x = {{IDX_W{1'b0}}, box_min_col};
	assign max_col_x = {{IDX_W{1'b0}}, box_max_col};

	// Multiply stage: cell offsets times resolution
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (rdy_s2) begin
			valid_s2 <= box_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s2 && box_valid) begin
			found_s2   <= box_found;
			top_s2     <= min_row_x[IDX_W-1:0];
			bottom_s2  <= max_row_x[IDX_W-1:0];
			left_s2    <= min_col_x[IDX_W-1:0];
			right_s2   <= max_col_x[IDX_W-1:0];
			p_north_s2 <= PRW'(box_min_row) * PRW'(ns_resolution);
			p_south_s2 <= (PRW'(box_max_row) + PRW'(1)) * PRW'(ns_resolution);
			p_west_s2  <= PCW'(box_min_col) * PCW'(ew_resolution);
			p_east_s2  <= (PCW'(box_max_col) + PCW'(1)) * PCW'(ew_resolution);
		end
	end

	// Offset the frame edges by the products
	always_comb begin
		n_x       = {{(SW-COORD_W){north_edge[COORD_W-1]}}, north_edge};
		w_x       = {{(SW-COORD_W){west_edge[COORD_W-1]}}, west_edge};
		sum_north = n_x - $signed({{(SW-PRW){1'b0}}, p_north_s2});
		sum_south = n_x - $signed({{(SW-PRW){1'b0}}, p_south_s2});
		sum_west  = w_x + $signed({{(SW-PCW){1'b0}}, p_west_s2});
		sum_east  = w_x + $signed({{(SW-PCW){1'b0}}, p_east_s2});
	end

	// Output register; an empty frame reports all zeros
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (rdy_s3) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s3 && valid_s2) begin
			found_s3 <= found_s2;
			if (found_s2) begin
				top_s3    <= top_s2;
				bottom_s3 <= bottom_s2;
				left_s3   <= left_s2;
				right_s3  <= right_s2;
				north_s3  <= sat_coord(sum_north);
				south_s3  <= sat_coord(sum_south);
				west_s3   <= sat_coord(sum_west);
				east_s3   <= sat_coord(sum_east);
			end else begin
				top_s3    <= '0;
				bottom_s3 <= '0;
				left_s3   <= '0;
				right_s3  <= '0;
				north_s3  <= '0;
				south_s3  <= '0;
				west_s3   <= '0;
				east_s3   <= '0;
			end
		end
	end

	assign out_valid  = valid_s3;
	assign found      = found_s3;
	assign top_row    = top_s3;
	assign bottom_row = bottom_s3;
	assign left_col   = left_s3;
	assign right_col  = right_s3;
	assign new_north  = north_s3;
	assign new_south  = south_s3;
	assign new_west   = west_s3;
	assign new_east   = east_s3;

endmodule

// File: rtl/core/valid_pixel_bounding_box_unit.sv
// Top level of the valid pixel bounding box unit: configuration and pipeline.
//
// Input channel (in_valid/in_ready, has_data) carries one raster cell per
// transaction in row-major order; has_data is 1 for a data cell, 0 for null.
// Output channel (out_valid/out_ready) carries one transaction per frame after
// its last cell: found, the box in cells and the tightened map edges.
// An empty frame gives found = 0 with every other field 0.
// Configuration: write cfg_data to register cfg_index while cfg_we is high,
// only while the unit is idle. Frame size is clamped to 1..MAX_ROWS/MAX_COLS.
// Throughput: one cell per cycle while in_ready is high (see Stall below).
// Path: the last cell of a frame is registered in the frame stage, then
// passes the multiply stage and the add/saturate output register.
// Stall: while out_ready is low the output holds; cells that do not end a
// frame keep flowing, and a frame-ending cell waits only if all stages are full.
// Reset: arst_n clears counters, box and pipeline valids and loads register
// defaults (1 x 1 frame, edges 0, resolutions 1.0).
`include "valid_pixel_bounding_box_unit_defines.svh"

module valid_pixel_bounding_box_unit import vpbb_pkg::*; #(
	parameter int MAX_ROWS = DEF_MAX_ROWS,
	parameter int MAX_COLS = DEF_MAX_COLS
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [CFG_IDX_W-1:0]      cfg_index,
	input  logic [CFG_DATA_W-1:0]     cfg_data,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic                      has_data,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic                      found,
	output logic [IDX_W-1:0]          top_row,
	output logic [IDX_W-1:0]          bottom_row,
	output logic [IDX_W-1:0]          left_col,
	output logic [IDX_W-1:0]          right_col,
	output logic signed [COORD_W-1:0] new_north,
	output logic signed [COORD_W-1:0] new_south,
	output logic signed [COORD_W-1:0] new_west,
	output logic signed [COORD_W-1:0] new_east
);

	localparam int RW = $clog2(MAX_ROWS);
	localparam int CW = $clog2(MAX_COLS);

	logic [CFG_ROWS_W-1:0]     frame_rows_q;
	logic [CFG_COLS_W-1:0]     frame_cols_q;
	logic signed [COORD_W-1:0] north_edge_q, west_edge_q;
	logic [RES_W-1:0]          ns_res_q, ew_res_q;

	logic          box_valid, box_ready, box_found;
	logic [RW-1:0] box_min_row, box_max_row;
	logic [CW-1:0] box_min_col, box_max_col;

	// Configuration register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_rows_q <= CFG_ROWS_W'(1);
			frame_cols_q <= CFG_COLS_W'(1);
			north_edge_q <= '0;
			west_edge_q  <= '0;
			ns_res_q     <= RES_RESET;
			ew_res_q     <= RES_RESET;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				REG_FRAME_ROWS:    frame_rows_q <= cfg_data[CFG_ROWS_W-1:0];
				REG_FRAME_COLS:    frame_cols_q <= cfg_data[CFG_COLS_W-1:0];
				REG_NORTH_EDGE:    north_edge_q <= cfg_data[COORD_W-1:0];
				REG_WEST_EDGE:     west_edge_q  <= cfg_data[COORD_W-1:0];
				REG_NS_RESOLUTION: ns_res_q     <= cfg_data[RES_W-1:0];
				REG_EW_RESOLUTION: ew_res_q     <= cfg_data[RES_W-1:0];
				default: ;
			endcase
		end
	end

	vpbb_tracker #(
		.MAX_ROWS(MAX_ROWS),
		.MAX_COLS(MAX_COLS)
	) u_tracker (
		.clk        (clk),
		.arst_n     (arst_n),
		.frame_rows (frame_rows_q),
		.frame_cols (frame_cols_q),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.has_data   (has_data),
		.box_valid  (box_valid),
		.box_ready  (box_ready),
		.box_found  (box_found),
		.box_min_row(box_min_row),
		.box_max_row(box_max_row),
		.box_min_col(box_min_col),
		.box_max_col(box_max_col)
	);

	vpbb_edge_calc #(
		.MAX_ROWS(MAX_ROWS),
		.MAX_COLS(MAX_COLS)
	) u_edge_calc (
		.clk          (clk),
		.arst_n       (arst_n),
		.north_edge   (north_edge_q),
		.west_edge    (west_edge_q),
		.ns_resolution(ns_res_q),
		.ew_resolution(ew_res_q),
		.box_valid    (box_valid),
		.box_ready    (box_ready),
		.box_found    (box_found),
		.box_min_row  (box_min_row),
		.box_max_row  (box_max_row),
		.box_min_col  (box_min_col),
		.box_max_col  (box_max_col),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.found        (found),
		.top_row      (top_row),
		.bottom_row   (bottom_row),
		.left_col     (left_col),
		.right_col    (right_col),
		.new_north    (new_north),
		.new_south    (new_south),
		.new_west     (new_west),
		.new_east     (new_east)
	);

	// An empty frame reports zero box and zero edges
	`VPBB_ASSERT_IMPL(a_empty_zero, clk, arst_n, out_valid && !found, top_row == '0 && right_col == '0 && new_north == '0 && new_east == '0)
	// Edges of a found box stay ordered
	`VPBB_ASSERT_IMPL(a_ns_order, clk, arst_n, out_valid && found, new_north >= new_south)
	`VPBB_ASSERT_ALWAYS(a_ew_order, clk, arst_n, !(out_valid && found) || (new_east >= new_west))

endmodule
